// ----- rtl/ptdt_pkg.sv -----
// Shared types and codes for the periodic task deadline table.
`default_nettype none
package ptdt_pkg;

  typedef enum logic [2:0] {
    KIND_FIRED    = 3'd0,
    KIND_ADD_OK   = 3'd1,
    KIND_ADD_FULL = 3'd2,
    KIND_WAIT     = 3'd3,
    KIND_RERUN    = 3'd4,
    KIND_EMPTY    = 3'd5
  } kind_t;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_SCAN = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] interval;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  task_index;
    logic [31:0] wake_time;
    logic        last;
  } rsp_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_LE  = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN_CMP,
    ST_SCAN_UPD,
    ST_SCAN_MIN,
    ST_SCAN_END
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/ptdt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/ptdt_alu.sv -----
// Shared 32-bit adder and unsigned less-or-equal comparator.
`default_nettype none
module ptdt_alu
  import ptdt_pkg::*;
(
  input  wire alu_req_t    req,
  output logic [31:0]      sum,
  output logic             le
);

  always_comb begin
    sum = 32'd0;
    le  = 1'b0;
    unique case (req.op)
      ALU_ADD: sum = req.a + req.b;
      ALU_LE:  le  = (req.a <= req.b);
      default: begin
        sum = 32'd0;
        le  = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/periodic_task_deadline_table.sv -----
// Top level of the periodic task deadline table: sequencer, stores and result register.
`default_nettype none
// Table of up to MAX_TASKS periodic tasks, each with a period and a next deadline.
// Issue a transaction by raising start with req while busy is low; the transaction
// is taken at that edge. An add appends a task whose deadline is now + interval
// (wrapping at 32 bits) and answers add ok with the new index, or add full when
// the table holds MAX_TASKS tasks. A scan walks the tasks in index order: each
// task whose deadline is at or before now gives a fired result and gets the new
// deadline period + now; a final result then carries the minimum deadline (the
// running minimum starts at task 0's deadline before the scan) and says wait
// (minimum after now) or rerun; an empty table answers empty. Every result sits
// on rsp for exactly one cycle with rsp_valid high and the receiver cannot stall
// it; last marks the final result of a transaction, and busy is already low in
// that cycle. All arithmetic runs through one shared adder/comparator that
// does one operation per cycle, and each task costs one compare of its deadline,
// one add when it fires, and one compare against the running minimum; the stores
// have a registered read port, so the next entry is fetched while the current
// one finishes.
module periodic_task_deadline_table
  import ptdt_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      rsp_valid,
  output rsp_t      rsp
);

  localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNTW = $clog2(MAX_TASKS + 1);

  state_t state, state_next;

  logic [CNTW-1:0] task_count;
  logic [IDXW-1:0] idx, idx_next;
  logic [31:0]     now_r, ival_r;
  logic [31:0]     cur, cur_next;
  logic [31:0]     minv, minv_next;

  logic            accept;
  logic            full;
  logic            last_entry;
  logic [CNTW-1:0] idx_ext;

  // Store ports
  logic            dl_we, pd_we;
  logic [IDXW-1:0] dl_waddr, wr_slot;
  logic [31:0]     dl_rdata, pd_rdata;

  // Shared unit
  alu_req_t        alu_req;
  logic [31:0]     alu_sum;
  logic            alu_le;

  // Result register inputs
  logic            res_load;
  rsp_t            res_next;
  logic [IDXW+3:0] idx_wide;
  logic [IDXW+3:0] slot_wide;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign full       = (task_count == CNTW'(MAX_TASKS));
  assign idx_ext    = CNTW'(idx);
  assign last_entry = ((idx_ext + CNTW'(1)) == task_count);
  assign wr_slot    = task_count[IDXW-1:0];
  assign idx_wide   = {4'd0, idx};
  assign slot_wide  = {4'd0, wr_slot};

  ptdt_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .le  (alu_le)
  );

  // Deadline store: written by add and by a fired task, read at the next index.
  ptdt_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (alu_sum),
    .raddr (idx_next),
    .rdata (dl_rdata)
  );

  // Period store: written only by add.
  ptdt_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_period_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (wr_slot),
    .wdata (ival_r),
    .raddr (idx_next),
    .rdata (pd_rdata)
  );

  // Next state and scan index
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          if (req.req_type == REQ_ADD) begin
            if (!full) state_next = ST_ADD;
          end else if (task_count != '0) begin
            state_next = ST_SCAN_CMP;
          end
        end
      end
      ST_ADD:      state_next = ST_IDLE;
      ST_SCAN_CMP: state_next = alu_le ? ST_SCAN_UPD : ST_SCAN_MIN;
      ST_SCAN_UPD: state_next = ST_SCAN_MIN;
      ST_SCAN_MIN: begin
        // advance; the store read for the next entry starts this cycle
        idx_next   = idx + IDXW'(1);
        state_next = last_entry ? ST_SCAN_END : ST_SCAN_CMP;
      end
      ST_SCAN_END: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    alu_req   = '{op: ALU_ADD, a: ival_r, b: now_r};
    dl_we     = 1'b0;
    dl_waddr  = idx;
    pd_we     = 1'b0;
    res_load  = 1'b0;
    res_next  = '{kind: KIND_FIRED, task_index: 4'd0, wake_time: 32'd0, last: 1'b1};
    cur_next  = cur;
    minv_next = minv;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_ADD) begin
            if (full) begin
              res_load      = 1'b1;
              res_next.kind = KIND_ADD_FULL;
            end
          end else if (task_count == '0) begin
            res_load      = 1'b1;
            res_next.kind = KIND_EMPTY;
          end
        end
      end
      ST_ADD: begin
        // deadline = interval + now, period = interval
        dl_we               = 1'b1;
        dl_waddr            = wr_slot;
        pd_we               = 1'b1;
        res_load            = 1'b1;
        res_next.kind       = KIND_ADD_OK;
        res_next.task_index = slot_wide[3:0];
      end
      ST_SCAN_CMP: begin
        alu_req  = '{op: ALU_LE, a: dl_rdata, b: now_r};
        cur_next = dl_rdata;
        if (idx == '0) minv_next = dl_rdata;
      end
      ST_SCAN_UPD: begin
        alu_req             = '{op: ALU_ADD, a: pd_rdata, b: now_r};
        dl_we               = 1'b1;
        cur_next            = alu_sum;
        res_load            = 1'b1;
        res_next.kind       = KIND_FIRED;
        res_next.task_index = idx_wide[3:0];
        res_next.last       = 1'b0;
      end
      ST_SCAN_MIN: begin
        alu_req = '{op: ALU_LE, a: minv, b: cur};
        if (!alu_le) minv_next = cur;
      end
      ST_SCAN_END: begin
        alu_req            = '{op: ALU_LE, a: minv, b: now_r};
        res_load           = 1'b1;
        res_next.kind      = alu_le ? KIND_RERUN : KIND_WAIT;
        res_next.wake_time = minv;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      task_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= res_load;
      if (state == ST_ADD) begin
        task_count <= task_count + CNTW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    cur  <= cur_next;
    minv <= minv_next;
    if (accept) begin
      now_r  <= req.now;
      ival_r <= req.interval;
    end
    if (res_load) begin
      rsp <= res_next;
    end
  end

  // Only the final result of a transaction is anything but a fired result.
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.kind == KIND_FIRED)
    else $error("non-final result is not a fired result");

  // The final result comes out as the sequencer returns to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> !busy)
    else $error("final result while still busy");

  // An accepted transaction either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> rsp_valid || busy)
    else $error("accepted transaction dropped");

  // The task count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= CNTW'(MAX_TASKS))
    else $error("task count beyond table size");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the periodic task deadline table: directed and random transactions.
module tb;
  import ptdt_pkg::*;

  localparam int TASK_SLOTS       = 16;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_WAIT       = 64;
  localparam int RANDOM_PER_PHASE = 150;

  // Track the task table, predict every result of an accepted transaction and
  // check the results the block delivers against them in order.
  class deadline_scoreboard;
    logic [31:0] next_deadline [TASK_SLOTS];
    logic [31:0] task_period   [TASK_SLOTS];
    int unsigned task_count = 0;
    int unsigned errors     = 0;
    rsp_t        due_rsp [$];

    function void add_due(kind_t kind, logic [3:0] idx, logic [31:0] wake, logic last);
      rsp_t r;
      r.kind       = kind;
      r.task_index = idx;
      r.wake_time  = wake;
      r.last       = last;
      due_rsp.push_back(r);
    endfunction

    function void note_request(req_t r);
      logic [31:0] lowest;
      int          i;
      if (r.req_type == REQ_ADD) begin
        if (task_count >= TASK_SLOTS) begin
          add_due(KIND_ADD_FULL, '0, '0, 1'b1);
        end else begin
          task_period[task_count]   = r.interval;
          next_deadline[task_count] = r.interval + r.now;
          add_due(KIND_ADD_OK, 4'(task_count), '0, 1'b1);
          task_count++;
        end
      end else if (task_count == 0) begin
        add_due(KIND_EMPTY, '0, '0, 1'b1);
      end else begin
        // The running minimum starts from task 0's deadline before the scan.
        lowest = next_deadline[0];
        for (i = 0; i < task_count; i++) begin
          if (next_deadline[i] <= r.now) begin
            add_due(KIND_FIRED, 4'(i), '0, 1'b0);
            next_deadline[i] = task_period[i] + r.now;
          end
          if (lowest > next_deadline[i]) lowest = next_deadline[i];
        end
        add_due((lowest > r.now) ? KIND_WAIT : KIND_RERUN, '0, lowest, 1'b1);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d index=%0d wake=%h last=%b",
                 $time, got.kind, got.task_index, got.wake_time, got.last);
        return;
      end
      want = due_rsp.pop_front();
      if (got.kind !== want.kind) begin
        errors++;
        $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind, got.kind);
      end
      if (got.task_index !== want.task_index) begin
        errors++;
        $display("%0t: task_index mismatch expected %0d actual %0d",
                 $time, want.task_index, got.task_index);
      end
      if (got.wake_time !== want.wake_time) begin
        errors++;
        $display("%0t: wake_time mismatch expected %h actual %h",
                 $time, want.wake_time, got.wake_time);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch expected %b actual %b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic rsp_valid;
  rsp_t rsp;

  deadline_scoreboard sb;
  int cycle_count = 0;

  periodic_task_deadline_table #(
    .MAX_TASKS(TASK_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sample at the rising edge: both the block's outputs and our own inputs still
  // hold their pre-edge values here. Check the result first, then note a new
  // transaction; the new one's results always come after the old one's.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid) sb.check_result(rsp);
      if (start && !busy) sb.note_request(req);
    end
  end

  function automatic req_t make_req(req_type_t kind, logic [31:0] interval, logic [31:0] now);
    req_t r;
    r.req_type = kind;
    r.interval = interval;
    r.now      = now;
    return r;
  endfunction

  // Present one transaction and hold it until the block takes it. Keep start high
  // when the next one follows at once; otherwise drop start for the idle gap.
  task automatic send_req(input req_t item, input int gap);
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int          idle_pct [3];
    int          phase;
    int          n;
    int          roll;
    int          sel;
    int          gap;
    logic [31:0] tick;
    req_t        item;

    idle_pct[0] = 36;
    idle_pct[1] = 51;
    idle_pct[2] = 0;
    sb = new;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, wrapping adds, deadlines at and around now,
    // the minimum seeded from task 0's old deadline, wait and rerun endings.
    send_req(make_req(REQ_SCAN, '0, '0), 0);
    send_req(make_req(REQ_SCAN, '1, '1), 1);
    send_req(make_req(REQ_ADD, '0, '0), 0);
    send_req(make_req(REQ_ADD, '1, 32'd1), 0);
    send_req(make_req(REQ_ADD, 32'h8000_0000, 32'h8000_0000), 2);
    send_req(make_req(REQ_ADD, 32'd5, 32'd10), 0);
    send_req(make_req(REQ_ADD, '1, '1), 0);
    send_req(make_req(REQ_SCAN, '0, '0), 0);
    send_req(make_req(REQ_SCAN, '1, 32'd14), 1);
    send_req(make_req(REQ_SCAN, '0, 32'd15), 0);
    send_req(make_req(REQ_SCAN, '0, '1), 0);
    send_req(make_req(REQ_SCAN, '0, 32'd1), 2);
    send_req(make_req(REQ_ADD, 32'd1, '1), 0);
    send_req(make_req(REQ_SCAN, 32'hAAAA_AAAA, 32'h5555_5555), 0);
    send_req(make_req(REQ_SCAN, 32'h5555_5555, 32'hAAAA_AAAA), 1);
    send_req(make_req(REQ_ADD, 32'h5555_5555, 32'hAAAA_AAAA), 0);

    // Random part: mostly a time base that moves forward with short periods so
    // that deadlines cluster around now, plus jumps, wrap-arounds and noise.
    tick = 32'd1000;
    for (phase = 0; phase < 3; phase++) begin
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 18) begin
          item.req_type = REQ_ADD;
          sel = $urandom_range(0, 9);
          case (sel)
            7: item.interval = $urandom();
            8: item.interval = '1;
            9: item.interval = '0;
            default: item.interval = $urandom_range(1, 400);
          endcase
          item.now = ($urandom_range(0, 9) < 8) ? tick : $urandom();
        end else begin
          item.req_type = REQ_SCAN;
          item.interval = $urandom();
          sel = $urandom_range(0, 99);
          if (sel < 2) tick = 32'hFFFF_FF00 + $urandom_range(0, 255);
          else if (sel < 4) tick = $urandom();
          else tick = tick + $urandom_range(0, 120);
          sel = $urandom_range(0, 99);
          if (sel < 85) item.now = tick;
          else if (sel < 95) item.now = $urandom();
          else item.now = $urandom_range(0, 1) ? '1 : '0;
        end
        gap = ($urandom_range(0, 99) < idle_pct[phase]) ? $urandom_range(1, 6) : 0;
        send_req(item, gap);
      end
    end
    start <= 1'b0;

    // Drain: wait for every predicted result, then a scan's worth of cycles more
    // to catch anything extra.
    while (sb.due_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.due_rsp.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.due_rsp.size());
    end
    if (sb.errors == 0 && sb.due_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ptdt_pkg.sv
rtl/ptdt_ram.sv
rtl/ptdt_alu.sv
rtl/periodic_task_deadline_table.sv
dv/tb.sv
